FILE: rtl/bce_pkg.sv
// Shared types and constants for the battery charge estimator.
// No dependencies; the divider, the estimator and the testbench import this package.
package bce_pkg;

    // Divider operand widths: dividend up to 65535 * 100 * 60, divisor up to 32768 * 100.
    localparam int NUM_W = 29;
    localparam int DEN_W = 22;
    localparam int CNT_W = 5;

    // Item kinds.
    localparam logic CMD_TABLE = 1'b0;
    localparam logic CMD_MEAS  = 1'b1;

    // Charge status codes that matter to the flags.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DEAD    = 3'd2;
    localparam logic [2:0] ST_TRICKLE = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd5;

    // Battery level codes.
    localparam logic [1:0] LVL_HIGH = 2'd0;
    localparam logic [1:0] LVL_LOW  = 2'd1;
    localparam logic [1:0] LVL_CRIT = 2'd2;

    // Reset values and fixed factors.
    localparam logic [15:0] MIN_MV_RST = 16'd3400;
    localparam logic [15:0] MAX_MV_RST = 16'd4200;
    localparam logic [6:0]  PCT_FULL   = 7'd100;
    localparam logic [6:0]  MIN_PER_H  = 7'd60;
    localparam logic [6:0]  LVL_HIGH_TH = 7'd50;
    localparam logic [6:0]  LVL_LOW_TH  = 7'd25;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_MIN_MV  = 2'd0,
        REG_MAX_MV  = 2'd1,
        REG_FULL    = 2'd2,
        REG_ENTRIES = 2'd3
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK0,
        S_CHKN,
        S_WALK,
        S_LIN,
        S_MUL,
        S_CSTART,
        S_CWAIT,
        S_CFIN,
        S_MIN,
        S_MMUL,
        S_MSTART,
        S_MWAIT,
        S_DONE
    } state_t;

    // Request to and response from the shared divider.
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

FILE: rtl/bce_ifs.sv
// Valid/ready channel interfaces for input and result words.
// Standalone; widths follow the field list of the estimator.
interface bce_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [3:0]         entry_index;
    logic [15:0]        entry_voltage_mv;
    logic [6:0]         entry_capacity_pct;
    logic               battery_present;
    logic signed [15:0] voltage_mv;
    logic signed [15:0] current_ma;
    logic [2:0]         charge_status;

    modport source (output valid, cmd, entry_index, entry_voltage_mv, entry_capacity_pct,
                    battery_present, voltage_mv, current_ma, charge_status, input ready);
    modport sink   (input valid, cmd, entry_index, entry_voltage_mv, entry_capacity_pct,
                    battery_present, voltage_mv, current_ma, charge_status, output ready);
endinterface

interface bce_out_if;
    logic               valid;
    logic               ready;
    logic               present_out;
    logic               voltage_valid;
    logic [6:0]         capacity_pct;
    logic               charging_flag;
    logic               discharging_flag;
    logic signed [16:0] reported_current_ma;
    logic signed [22:0] time_to_empty_min;
    logic               ac_on;
    logic [1:0]         battery_level;

    modport source (output valid, present_out, voltage_valid, capacity_pct, charging_flag,
                    discharging_flag, reported_current_ma, time_to_empty_min, ac_on,
                    battery_level, input ready);
    modport sink   (input valid, present_out, voltage_valid, capacity_pct, charging_flag,
                    discharging_flag, reported_current_ma, time_to_empty_min, ac_on,
                    battery_level, output ready);
endinterface

FILE: rtl/bce_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on bce_pkg for operand widths and the request/response structs.
module bce_div (
    input  logic              clk,
    input  logic              rst_n,
    input  bce_pkg::div_req_t req,
    output bce_pkg::div_rsp_t rsp
);
    import bce_pkg::*;

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // Shift in the next dividend bit and try the subtraction.
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath; the quotient collects in the dividend register.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], fits};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;

endmodule

FILE: rtl/bce_table.sv
// Voltage/capacity table memory with one write port and one registered read port.
// Depends on nothing but its depth parameter.
module bce_table #(
    parameter int DEPTH = 16,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [15:0]      wvolt,
    input  logic [6:0]       wcap,
    input  logic [IDX_W-1:0] raddr,
    output logic [15:0]      rvolt,
    output logic [6:0]       rcap
);
    logic [15:0] volt_mem [DEPTH];
    logic [6:0]  cap_mem  [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            volt_mem[waddr] <= wvolt;
            cap_mem[waddr]  <= wcap;
        end
        rvolt <= volt_mem[raddr];
        rcap  <= cap_mem[raddr];
    end

endmodule

FILE: rtl/battery_charge_estimator.sv
// Battery charge estimator: table lookup or linear map, then a minutes estimate.
// A table write or an absent battery goes to S_DONE once accepted and is registered when the
// output register is free; a measurement takes a walk of up to TABLE_DEPTH - 1 entries, up to
// two divisions on the shared divider, and the sequencing states around them.
// Throughput: one word at a time; the input is ready again the cycle after the result is registered.
// Reset (rst_n, async low): registers to 3400/4200/0/0, capacity 0, minutes -1, status idle.
// The table memory is not cleared and must be written before it is used.
module battery_charge_estimator #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    bce_in_if.sink      in_ch,
    bce_out_if.source   out_ch
);
    import bce_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int NCNT_W = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0] min_mv_reg, max_mv_reg, full_reg;
    logic [4:0]  entries_reg;

    // Held state.
    logic [6:0]         held_cap_reg;
    logic signed [22:0] held_min_reg;
    logic [2:0]         held_status_reg;

    // Item and working registers.
    logic               cmd_reg, pres_reg, vvalid_reg;
    logic [15:0]        v_reg;
    logic signed [15:0] cur_reg;
    logic [15:0]        prev_v_reg;
    logic [6:0]         prev_c_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [15:0]        dv_reg;
    logic [6:0]         dc_reg;
    logic               neg_reg, direct_reg;
    logic [6:0]         base_reg, cap_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;

    // Output register.
    logic               out_valid_reg;
    logic               o_pres_reg, o_vvalid_reg, o_chg_reg, o_dis_reg, o_ac_reg;
    logic [6:0]         o_cap_reg;
    logic signed [16:0] o_cur_reg;
    logic signed [22:0] o_min_reg;
    logic [1:0]         o_lvl_reg;

    // Control from the sequencer.
    logic             in_acc, tbl_we, div_start, out_load;
    logic [IDX_W-1:0] rd_addr;
    logic [15:0]      rd_volt;
    logic [6:0]       rd_cap;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    // Derived values.
    logic [NCNT_W-1:0]  n_used;
    logic [IDX_W-1:0]   last_addr;
    logic               cur_neg;
    logic signed [16:0] cur_mag;
    logic               charging;
    logic signed [23:0] cap_sum;
    logic [6:0]         cap_clamped;
    logic [22:0]        q_term;

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign tbl_we   = in_acc && (in_ch.cmd == CMD_TABLE)
                      && (32'(in_ch.entry_index) < TABLE_DEPTH);
    assign n_used   = (32'(entries_reg) > TABLE_DEPTH) ? NCNT_W'(TABLE_DEPTH)
                                                       : NCNT_W'(entries_reg);
    assign last_addr = IDX_W'(n_used - NCNT_W'(1));
    assign cur_neg  = cur_reg[15];
    assign cur_mag  = -{cur_reg[15], cur_reg};
    assign charging = (held_status_reg >= ST_DEAD) && (held_status_reg <= ST_DONE);

    // Capacity from base plus or minus the quotient, clamped to 0..100.
    assign q_term  = direct_reg ? '0 : div_rsp.quot[22:0];
    assign cap_sum = $signed({17'd0, base_reg})
                     + (neg_reg ? -$signed({1'b0, q_term}) : $signed({1'b0, q_term}));
    always_comb
    begin
        priority if (cap_sum < 0)
            cap_clamped = '0;
        else if (cap_sum > 24'sd100)
            cap_clamped = PCT_FULL;
        else
            cap_clamped = cap_sum[6:0];
    end

    bce_table #(.DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (IDX_W'(in_ch.entry_index)),
        .wvolt (in_ch.entry_voltage_mv),
        .wcap  (in_ch.entry_capacity_pct),
        .raddr (rd_addr),
        .rvolt (rd_volt),
        .rcap  (rd_cap)
    );

    assign div_req.start = div_start;
    assign div_req.num   = num_reg;
    assign div_req.den   = den_reg;

    bce_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.cmd == CMD_TABLE || !in_ch.battery_present)
                        state_next = S_DONE;
                    else if (in_ch.voltage_mv[15])
                        state_next = S_MIN;
                    else if (n_used != '0)
                        state_next = S_CHK0;
                    else
                        state_next = S_LIN;
                end
            end
            S_CHK0:   state_next = (v_reg >= rd_volt) ? S_CFIN : S_CHKN;
            S_CHKN:   state_next = (v_reg <= rd_volt) ? S_CFIN : S_WALK;
            S_WALK:
            begin
                if (v_reg >= rd_volt)
                    state_next = (prev_v_reg == rd_volt) ? S_CFIN : S_MUL;
            end
            S_LIN:
            begin
                if (v_reg <= min_mv_reg || v_reg >= max_mv_reg)
                    state_next = S_CFIN;
                else
                    state_next = S_MUL;
            end
            S_MUL:    state_next = S_CSTART;
            S_CSTART: state_next = S_CWAIT;
            S_CWAIT:  state_next = div_rsp.done ? S_CFIN : S_CWAIT;
            S_CFIN:   state_next = S_MIN;
            S_MIN:
            begin
                if (cur_neg && cap_reg != '0 && full_reg != '0)
                    state_next = S_MMUL;
                else
                    state_next = S_DONE;
            end
            S_MMUL:   state_next = S_MSTART;
            S_MSTART: state_next = S_MWAIT;
            S_MWAIT:  state_next = div_rsp.done ? S_DONE : S_MWAIT;
            S_DONE:   state_next = out_load ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ch.ready = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        rd_addr     = '0;
        unique case (state_reg)
            S_IDLE:   in_ch.ready = 1'b1;
            S_CHK0:   rd_addr = last_addr;
            S_CHKN:   rd_addr = IDX_W'(1);
            S_WALK:   rd_addr = idx_reg + IDX_W'(1);
            S_CSTART: div_start = 1'b1;
            S_MSTART: div_start = 1'b1;
            S_DONE:   out_load = !out_valid_reg || out_ch.ready;
            default:  rd_addr = '0;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mv_reg  <= MIN_MV_RST;
            max_mv_reg  <= MAX_MV_RST;
            full_reg    <= '0;
            entries_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_MV:  min_mv_reg  <= cfg_data;
                REG_MAX_MV:  max_mv_reg  <= cfg_data;
                REG_FULL:    full_reg    <= cfg_data;
                REG_ENTRIES: entries_reg <= cfg_data[4:0];
                default:     entries_reg <= entries_reg;
            endcase
        end
    end

    // Control and held state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            held_cap_reg    <= '0;
            held_min_reg    <= '1;
            held_status_reg <= ST_IDLE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc && in_ch.cmd == CMD_MEAS && in_ch.battery_present)
                held_status_reg <= in_ch.charge_status;
            if (state_reg == S_CFIN)
                held_cap_reg <= cap_clamped;
            if (state_reg == S_MIN && state_next == S_DONE)
                held_min_reg <= '1;
            if (state_reg == S_MWAIT && div_rsp.done)
                held_min_reg <= $signed(div_rsp.quot[22:0]);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working datapath.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_reg    <= in_ch.cmd;
                    pres_reg   <= in_ch.battery_present;
                    v_reg      <= in_ch.voltage_mv;
                    cur_reg    <= in_ch.current_ma;
                    vvalid_reg <= 1'b0;
                    cap_reg    <= '0;
                end
            end
            S_CHK0:
            begin
                base_reg   <= rd_cap;
                direct_reg <= 1'b1;
                neg_reg    <= 1'b0;
                prev_v_reg <= rd_volt;
                prev_c_reg <= rd_cap;
            end
            S_CHKN:
            begin
                base_reg   <= rd_cap;
                direct_reg <= 1'b1;
                neg_reg    <= 1'b0;
                idx_reg    <= IDX_W'(1);
            end
            S_WALK:
            begin
                if (v_reg >= rd_volt)
                begin
                    // Interpolate between the previous entry and this one.
                    direct_reg <= (prev_v_reg == rd_volt);
                    base_reg   <= (prev_v_reg == rd_volt) ? prev_c_reg : rd_cap;
                    neg_reg    <= (prev_c_reg < rd_cap) && (prev_v_reg != rd_volt);
                    dv_reg     <= v_reg - rd_volt;
                    dc_reg     <= (prev_c_reg < rd_cap) ? rd_cap - prev_c_reg
                                                        : prev_c_reg - rd_cap;
                    den_reg    <= DEN_W'(prev_v_reg - rd_volt);
                end
                else
                begin
                    prev_v_reg <= rd_volt;
                    prev_c_reg <= rd_cap;
                    idx_reg    <= idx_reg + IDX_W'(1);
                end
            end
            S_LIN:
            begin
                // Linear map between the design minimum and maximum.
                neg_reg    <= 1'b0;
                direct_reg <= (v_reg <= min_mv_reg) || (v_reg >= max_mv_reg);
                base_reg   <= (v_reg <= min_mv_reg) ? 7'd0
                              : ((v_reg >= max_mv_reg) ? PCT_FULL : 7'd0);
                dv_reg     <= v_reg - min_mv_reg;
                dc_reg     <= PCT_FULL;
                den_reg    <= DEN_W'(max_mv_reg - min_mv_reg);
            end
            S_MUL:    num_reg <= NUM_W'(dv_reg) * NUM_W'(dc_reg);
            S_CFIN:
            begin
                cap_reg    <= cap_clamped;
                vvalid_reg <= 1'b1;
            end
            S_MIN:
            begin
                // Minutes = full * cap * 60 / (|current| * 100).
                dv_reg  <= 16'(cap_reg) * 16'(MIN_PER_H);
                den_reg <= DEN_W'(cur_mag[15:0]) * DEN_W'(PCT_FULL);
            end
            S_MMUL:   num_reg <= NUM_W'(full_reg) * NUM_W'(dv_reg);
            default:  idx_reg <= idx_reg;
        endcase
    end

    // Result word.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_pres_reg   <= (cmd_reg == CMD_MEAS) && pres_reg;
            o_vvalid_reg <= (cmd_reg == CMD_MEAS) && pres_reg && vvalid_reg;
            o_cap_reg    <= held_cap_reg;
            o_chg_reg    <= charging;
            o_ac_reg     <= (held_status_reg >= ST_TRICKLE) && (held_status_reg <= ST_DONE);
            o_min_reg    <= held_min_reg;
            if (cmd_reg == CMD_MEAS && pres_reg)
            begin
                o_dis_reg <= !charging && cur_neg;
                o_cur_reg <= (!charging && cur_neg) ? cur_mag : 17'(cur_reg);
            end
            else
            begin
                o_dis_reg <= 1'b0;
                o_cur_reg <= '0;
            end
            priority if (held_cap_reg > LVL_HIGH_TH)
                o_lvl_reg <= LVL_HIGH;
            else if (held_cap_reg > LVL_LOW_TH)
                o_lvl_reg <= LVL_LOW;
            else
                o_lvl_reg <= LVL_CRIT;
        end
    end

    assign out_ch.valid               = out_valid_reg;
    assign out_ch.present_out         = o_pres_reg;
    assign out_ch.voltage_valid       = o_vvalid_reg;
    assign out_ch.capacity_pct        = o_cap_reg;
    assign out_ch.charging_flag       = o_chg_reg;
    assign out_ch.discharging_flag    = o_dis_reg;
    assign out_ch.reported_current_ma = o_cur_reg;
    assign out_ch.time_to_empty_min   = o_min_reg;
    assign out_ch.ac_on               = o_ac_reg;
    assign out_ch.battery_level       = o_lvl_reg;

    // The divider is only started when it is free.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // An accepted word closes the input until its result is registered.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ch.ready)
        else $error("input ready right after accept");

    // A valid voltage implies a present battery.
    a_vvalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.voltage_valid |-> out_ch.present_out)
        else $error("voltage valid without presence");

    // A discharging result reports a nonnegative current.
    a_dis_mag: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.discharging_flag |-> !out_ch.reported_current_ma[16])
        else $error("negative current while discharging");

endmodule

FILE: dv/battery_charge_estimator_tb.sv
// Self-checking testbench for the battery charge estimator: table writes and measurements
// are predicted in the testbench and each result word is compared field by field.
// Depends on rtl/bce_pkg.sv, rtl/bce_ifs.sv and rtl/battery_charge_estimator.sv.
module battery_charge_estimator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bce_pkg::*;

    localparam int DEPTH = 16;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic               present_out;
        logic               voltage_valid;
        logic [6:0]         capacity_pct;
        logic               charging_flag;
        logic               discharging_flag;
        logic signed [16:0] reported_current_ma;
        logic signed [22:0] time_to_empty_min;
        logic               ac_on;
        logic [1:0]         battery_level;
    } gauge_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    bce_in_if  in_ch ();
    bce_out_if out_ch ();

    battery_charge_estimator #(.TABLE_DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    // Predictor state.
    int unsigned g_min_mv, g_max_mv, g_full_mah, g_entries;
    int unsigned ocv_mv [DEPTH];
    int unsigned ocv_pct [DEPTH];
    int unsigned hold_cap, hold_status;
    int          hold_minutes;

    gauge_word_t expected_words [$];
    int          errors;
    int          cycles;
    bit          hold_off;
    bit          bp_start;
    bit          rx_stall;

    // Clock and cycle limit.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Capacity from the table or the linear map, saturated to 0..100.
    function automatic int unsigned soc_from_voltage(input longint v);
        longint c, v1, v2, c1, c2;
        int unsigned n;
        bit found;
        n = (g_entries > DEPTH) ? DEPTH : g_entries;
        c = 0;
        found = 0;
        if (n > 0)
        begin
            if (v >= ocv_mv[0])
                c = ocv_pct[0];
            else if (v <= ocv_mv[n-1])
                c = ocv_pct[n-1];
            else
                for (int i = 1; i < n; i++)
                    if (!found && v >= ocv_mv[i])
                    begin
                        found = 1;
                        v1 = ocv_mv[i-1]; v2 = ocv_mv[i];
                        c1 = ocv_pct[i-1]; c2 = ocv_pct[i];
                        c = (v1 == v2) ? c1 : c2 + (v - v2) * (c1 - c2) / (v1 - v2);
                    end
        end
        else if (v <= g_min_mv)
            c = 0;
        else if (v >= g_max_mv)
            c = 100;
        else
            c = (v - g_min_mv) * 100 / (longint'(g_max_mv) - g_min_mv);
        if (c < 0) c = 0;
        if (c > 100) c = 100;
        return int'(c);
    endfunction

    // Update the held gauge state for one word and queue the result it yields.
    task automatic predict_gauge(input logic cmd, input logic [3:0] idx, input logic [15:0] ev,
                                 input logic [6:0] ec, input logic pres,
                                 input logic signed [15:0] v, input logic signed [15:0] cur,
                                 input logic [2:0] st);
        gauge_word_t w;
        int unsigned cap;
        longint rep;
        w = '0;
        rep = 0;
        if (cmd == CMD_TABLE)
        begin
            ocv_mv[idx] = 32'(ev);
            ocv_pct[idx] = 32'(ec);
        end
        else if (pres)
        begin
            cap = 0;
            w.present_out = 1;
            if (v >= 0)
            begin
                cap = soc_from_voltage(longint'(v));
                hold_cap = cap;
                w.voltage_valid = 1;
            end
            hold_status = 32'(st);
            rep = longint'(cur);
            if (!(st >= ST_DEAD && st <= ST_DONE) && cur < 0)
            begin
                w.discharging_flag = 1;
                rep = -longint'(cur);
            end
            if (cur < 0 && cap > 0 && g_full_mah > 0)
                hold_minutes = int'((longint'(g_full_mah) * cap * 60) / (-longint'(cur) * 100));
            else
                hold_minutes = -1;
        end
        w.reported_current_ma = rep[16:0];
        w.capacity_pct = hold_cap[6:0];
        w.charging_flag = hold_status >= ST_DEAD && hold_status <= ST_DONE;
        w.time_to_empty_min = hold_minutes[22:0];
        w.ac_on = hold_status >= ST_TRICKLE && hold_status <= ST_DONE;
        w.battery_level = hold_cap > 50 ? LVL_HIGH : (hold_cap > 25 ? LVL_LOW : LVL_CRIT);
        expected_words.push_back(w);
    endtask

    // Send one word, wait for acceptance, then possibly leave a gap.
    task automatic send_word(input logic cmd, input logic [3:0] idx, input logic [15:0] ev,
                             input logic [6:0] ec, input logic pres,
                             input logic signed [15:0] v, input logic signed [15:0] cur,
                             input logic [2:0] st);
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.entry_index <= idx;
        in_ch.entry_voltage_mv <= ev;
        in_ch.entry_capacity_pct <= ec;
        in_ch.battery_present <= pres;
        in_ch.voltage_mv <= v;
        in_ch.current_ma <= cur;
        in_ch.charge_status <= st;
        predict_gauge(cmd, idx, ev, ec, pres, v, cur, st);
        do @(posedge clk); while (!in_ch.ready);
        if ($urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic measure(input logic pres, input logic signed [15:0] v,
                           input logic signed [15:0] cur, input logic [2:0] st);
        send_word(CMD_MEAS, 4'($urandom), 16'($urandom), 7'($urandom), pres, v, cur, st);
    endtask

    task automatic load_entry(input logic [3:0] idx, input logic [15:0] ev, input logic [6:0] ec);
        send_word(CMD_TABLE, idx, ev, ec, 1'($urandom), 16'($urandom), 16'($urandom),
                  3'($urandom));
    endtask

    // Wait for the block to drain, then write one register.
    task automatic write_reg(input cfg_reg_t r, input logic [15:0] d);
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (r)
            REG_MIN_MV:  g_min_mv = 32'(d);
            REG_MAX_MV:  g_max_mv = 32'(d);
            REG_FULL:    g_full_mah = 32'(d);
            REG_ENTRIES: g_entries = 32'(d[4:0]);
        endcase
    endtask

    // Random measurement voltage, near the region of interest most of the time.
    function automatic logic signed [15:0] rand_volt();
        case ($urandom_range(0, 5))
            0: return -$signed({1'b0, 15'($urandom_range(1, 32767))});
            1: return 16'($urandom);
            default: return 16'($urandom_range(2800, 4500));
        endcase
    endfunction

    function automatic logic signed [15:0] rand_cur();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 3000));
            default: return -$signed({1'b0, 15'($urandom_range(1, 3000))});
        endcase
    endfunction

    // Write a descending table of n entries, with occasional oddities.
    task automatic load_table(input int n);
        int unsigned v;
        v = $urandom_range(4000, 4400);
        for (int i = 0; i < n; i++)
        begin
            load_entry(4'(i), 16'(v), ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                                : 7'(100 - i * 100 / n));
            if ($urandom_range(0, 7) != 0)
                v = v - $urandom_range(0, 120);
        end
    endtask

    task automatic test_linear_map();
        measure(1, 3400, -1000, 1);
        measure(1, 4200, -1000, 1);
        measure(1, 3800, -500, 0);
        measure(1, 16'sh7FFF, 16'sh8000, 1);
        measure(1, 16'sh8000, -100, 1);
        measure(1, 0, 16'sh7FFF, 4);
        write_reg(REG_FULL, 16'hFFFF);
        measure(1, 4100, -1, 1);
        measure(1, 4100, 16'sh8000, 7);
        measure(1, -5, -200, 1);
        measure(0, 4100, -200, 3);
        for (int s = 0; s < 8; s++)
            measure(1, 3900, -300, 3'(s));
        write_reg(REG_MIN_MV, 16'hFFFF);
        write_reg(REG_MAX_MV, 16'h0000);
        measure(1, 16'sh7FFF, -10, 6);
        measure(1, 100, -10, 6);
        write_reg(REG_MIN_MV, 16'h0000);
        write_reg(REG_MAX_MV, 16'hFFFF);
        measure(1, 16'sh7FFF, -10, 1);
    endtask

    task automatic test_table_lookup();
        load_entry(0, 16'hFFFF, 100);
        load_entry(1, 4000, 127);
        load_entry(2, 4000, 50);
        load_entry(3, 3500, 10);
        load_entry(4, 0, 0);
        write_reg(REG_ENTRIES, 5);
        measure(1, 16'sh7FFF, -700, 1);
        measure(1, 4000, -700, 1);
        measure(1, 3700, -700, 1);
        measure(1, 0, -700, 1);
        load_entry(15, 3000, 5);
        write_reg(REG_ENTRIES, 16'd31);
        for (int i = 5; i < 15; i++)
            load_entry(4'(i), 3000, 5);
        measure(1, 3200, -50, 1);
    endtask

    task automatic test_random();
        int n;
        for (int p = 0; p < 12; p++)
        begin
            n = (p % 3 == 0) ? 0 : $urandom_range(1, DEPTH);
            if (n > 0)
                load_table(n);
            write_reg(REG_ENTRIES, 16'(n));
            write_reg(REG_FULL, ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom));
            if (n == 0)
            begin
                write_reg(REG_MIN_MV, 16'($urandom_range(3000, 3600)));
                write_reg(REG_MAX_MV, 16'($urandom_range(3700, 4400)));
            end
            for (int k = 0; k < 60; k++)
                if ($urandom_range(0, 15) == 0)
                    load_entry(4'($urandom_range(n, DEPTH - 1)), 16'($urandom), 7'($urandom));
                else
                    measure($urandom_range(0, 9) != 0, rand_volt(), rand_cur(), 3'($urandom));
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering words.
    task automatic test_backpressure();
        bp_start = 1'b1;
        for (int k = 0; k < 20; k++)
            measure(1, rand_volt(), rand_cur(), 3'($urandom));
    endtask

    // Receiver stall pattern and the long hold-off.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 63) < 8)
            rx_stall <= ~rx_stall;
        out_ch.ready <= rst_n && !hold_off && !(rx_stall && $urandom_range(0, 1));
    end

    initial
    begin
        int held;
        hold_off = 1'b0;
        held = 0;
        wait (bp_start);
        hold_off = 1'b1;
        while (held < 3000)
        begin
            @(posedge clk);
            held++;
        end
        hold_off = 1'b0;
    end

    // Check each accepted result word against the oldest prediction.
    always @(posedge clk)
    begin
        gauge_word_t g, e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            g = '{out_ch.present_out, out_ch.voltage_valid, out_ch.capacity_pct,
                  out_ch.charging_flag, out_ch.discharging_flag, out_ch.reported_current_ma,
                  out_ch.time_to_empty_min, out_ch.ac_on, out_ch.battery_level};
            if (expected_words.size() == 0)
                report("unexpected word", 0, 0);
            else
            begin
                e = expected_words.pop_front();
                if (g.present_out !== e.present_out)
                    report("present_out", longint'(g.present_out), longint'(e.present_out));
                if (g.voltage_valid !== e.voltage_valid)
                    report("voltage_valid", longint'(g.voltage_valid),
                           longint'(e.voltage_valid));
                if (g.capacity_pct !== e.capacity_pct)
                    report("capacity_pct", longint'(g.capacity_pct), longint'(e.capacity_pct));
                if (g.charging_flag !== e.charging_flag)
                    report("charging_flag", longint'(g.charging_flag),
                           longint'(e.charging_flag));
                if (g.discharging_flag !== e.discharging_flag)
                    report("discharging_flag", longint'(g.discharging_flag),
                           longint'(e.discharging_flag));
                if (g.reported_current_ma !== e.reported_current_ma)
                    report("reported_current_ma", longint'(g.reported_current_ma),
                           longint'(e.reported_current_ma));
                if (g.time_to_empty_min !== e.time_to_empty_min)
                    report("time_to_empty_min", longint'(g.time_to_empty_min),
                           longint'(e.time_to_empty_min));
                if (g.ac_on !== e.ac_on)
                    report("ac_on", longint'(g.ac_on), longint'(e.ac_on));
                if (g.battery_level !== e.battery_level)
                    report("battery_level", longint'(g.battery_level),
                           longint'(e.battery_level));
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MIN_MV;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_MEAS;
        in_ch.entry_index = '0;
        in_ch.entry_voltage_mv = '0;
        in_ch.entry_capacity_pct = '0;
        in_ch.battery_present = 1'b0;
        in_ch.voltage_mv = '0;
        in_ch.current_ma = '0;
        in_ch.charge_status = '0;
        bp_start = 1'b0;
        g_min_mv = 3400; g_max_mv = 4200; g_full_mah = 0; g_entries = 0;
        hold_cap = 0; hold_status = 0; hold_minutes = -1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_linear_map();
        test_table_lookup();
        test_backpressure();
        test_random();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/bce_pkg.sv
rtl/bce_ifs.sv
rtl/bce_div.sv
rtl/bce_table.sv
rtl/battery_charge_estimator.sv
dv/battery_charge_estimator_tb.sv
